FILE: src/next_fit_boundary_tag_allocator_macros.svh
// Assertion macros for the next-fit boundary-tag allocator.
// Used by the top level; expects clk and rst_n in the calling scope.
`ifndef NEXT_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define NFBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfbt: same-cycle check failed");
`define NFBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfbt: next-cycle check failed");
`else
`define NFBT_ASSERT_IMP(lbl, ante, cons)
`define NFBT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/nfbt_pkg.sv
// Shared types and constants of the next-fit boundary-tag allocator.
// No dependencies.
package nfbt_pkg;

  // Request codes
  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_RESIZE  = 2'd3
  } action_t;

  localparam int unsigned SPLIT_MIN  = 16;  // smallest free remainder kept
  localparam int unsigned TAG_BYTES  = 8;   // header plus footer
  localparam int unsigned MIN_BLOCK  = 16;
  localparam int unsigned STATUS_OK  = 0;
  localparam int unsigned STATUS_OOM = 1;
  localparam int unsigned COPY_MAX   = 65535;

endpackage

FILE: src/nfbt_if.sv
// Channel interfaces of the allocator: request and result.
// Depends on nfbt_pkg.
interface nfbt_in_if;
  logic                  valid;
  logic                  ready;
  nfbt_pkg::action_t     action;
  logic [15:0]           block_address;
  logic [15:0]           request_size;
  modport source (output valid, action, block_address, request_size, input ready);
  modport sink   (input valid, action, block_address, request_size, output ready);
endinterface

interface nfbt_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] result_address;
  logic [15:0] copy_bytes;
  modport source (output valid, status, result_address, copy_bytes, input ready);
  modport sink   (input valid, status, result_address, copy_bytes, output ready);
endinterface

FILE: src/next_fit_boundary_tag_allocator.sv
// Top level of the next-fit boundary-tag allocator: sequencer and heap.
// Depends on nfbt_pkg, nfbt_if, nfbt_heap_mem and the macros header.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | action, block_address, request_size
//  out_ch   | out | valid/ready   | status, result_address, copy_bytes
//
// Heap reads and writes share one memory port.
// Allocate walks headers from the rover, then places the block and answers; growth extends the break.
// Release frees and coalesces the block; init writes the tags and grows the heap; resize walks followers.
// Reset clears state, output valid, break, rover and mode flags; heap words are undefined until init.
// A finished result waits in the output register; a new transaction is taken
// meanwhile, and its result holds in the sequencer until the register frees.
`include "next_fit_boundary_tag_allocator_macros.svh"
module next_fit_boundary_tag_allocator #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  nfbt_in_if.sink    in_ch,
  nfbt_out_if.source out_ch
);
  import nfbt_pkg::*;

  localparam int WORDS    = HEAP_BYTES / 4;
  localparam int IW       = $clog2(WORDS);
  localparam int HB       = $clog2(HEAP_BYTES);
  localparam int AW       = (HB + 2 > 18) ? HB + 2 : 18;
  localparam int INIT_EXT = (CHUNK_BYTES / 4 + 1) / 2 * 8;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RD, S_WR, S_INIT_EXT, S_AL_START, S_FIT_CHK, S_EXT,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M_DEC, S_M_NF, S_M_END,
    S_PL_DEC, S_AL_OK, S_REL, S_REL_W, S_RS_OLD, S_RS_T, S_RS_N, S_DONE
  } state_t;

  state_t          state_r, cont_r;
  action_t         op_r;
  logic [AW-1:0]   brk_r, rover_r, p_r, bp_r, prev_r, psz_r, sz_r, nxt_r;
  logic [AW-1:0]   asize_r, ext_incr_r, old_r, tot_r, t_r, rd_addr_r;
  logic [16:0]     size_r, need_r;
  logic            pa_r, moving_r, ext_mode_r;
  logic [AW-1:0]   wa_r [4];
  logic [31:0]     wv_r [4];
  logic [1:0]      wcnt_r, widx_r;
  logic            res_status_r;
  logic [AW-1:0]   res_addr_r;
  logic [15:0]     res_copy_r;
  logic            out_valid_r, out_status_r;
  logic [15:0]     out_addr_r, out_copy_r;
  logic            rd_oob_r;

  logic [AW-1:0]   mem_byte;
  logic            mem_oob, mem_we;
  logic [31:0]     mem_rdata, rd_word;
  logic [AW-1:0]   rd_size;
  logic            rd_used;
  logic [AW:0]     ext_sum;
  logic [AW-1:0]   asize_calc, rs_tot, copy_full;
  logic [15:0]     copy_sat;

  // memory port: writes drain the queue, otherwise the pending read address
  assign mem_byte = (state_r == S_WR) ? wa_r[widx_r] : rd_addr_r;
  assign mem_oob  = (mem_byte >= AW'(HEAP_BYTES));
  assign mem_we   = (state_r == S_WR) && !mem_oob;

  nfbt_heap_mem #(.WORDS(WORDS), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_byte[IW+1:2]),
    .wdata (wv_r[widx_r]),
    .rdata (mem_rdata)
  );

  // decoded tag of the last read
  assign rd_word = rd_oob_r ? 32'd0 : mem_rdata;
  assign rd_size = {rd_word[AW-1:3], 3'b000};
  assign rd_used = rd_word[0];

  assign ext_sum    = {1'b0, brk_r} + {1'b0, ext_incr_r};
  assign asize_calc = (size_r <= 17'd8) ? AW'(MIN_BLOCK)
                    : ((AW'(size_r) + AW'(15)) & ~AW'(7));
  assign rs_tot     = tot_r + rd_size;
  assign copy_full  = (old_r >= AW'(TAG_BYTES)) ? old_r - AW'(TAG_BYTES) : '0;
  assign copy_sat   = (copy_full > AW'(COPY_MAX)) ? 16'(COPY_MAX) : copy_full[15:0];

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.copy_bytes     = out_copy_r;

  // sequencer: state, work registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      brk_r       <= '0;
      rover_r     <= '0;
      ext_mode_r  <= 1'b0;
      moving_r    <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r <= (in_ch.action == ACT_RESIZE && in_ch.block_address == 16'd0)
                    ? ACT_ALLOC : in_ch.action;
            p_r        <= AW'(in_ch.block_address);
            size_r     <= 17'(in_ch.request_size);
            moving_r   <= 1'b0;
            ext_mode_r <= 1'b0;
            state_r    <= S_DISP;
          end
        end
        S_DISP: begin
          res_status_r <= 1'(STATUS_OK);
          res_addr_r   <= '0;
          res_copy_r   <= '0;
          case (op_r)
            ACT_INIT: begin
              // padding, prologue and epilogue
              brk_r   <= AW'(16);
              rover_r <= AW'(8);
              wa_r[0] <= AW'(0);  wv_r[0] <= 32'd0;
              wa_r[1] <= AW'(4);  wv_r[1] <= 32'd9;
              wa_r[2] <= AW'(8);  wv_r[2] <= 32'd9;
              wa_r[3] <= AW'(12); wv_r[3] <= 32'd1;
              wcnt_r  <= 2'd3;
              widx_r  <= 2'd0;
              cont_r  <= S_INIT_EXT;
              state_r <= S_WR;
            end
            ACT_ALLOC: state_r <= S_AL_START;
            ACT_RELEASE: state_r <= (p_r == '0) ? S_DONE : S_REL;
            ACT_RESIZE: begin
              rd_addr_r <= p_r - AW'(4);
              cont_r    <= S_RS_OLD;
              state_r   <= S_RD;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_RD: begin
          rd_oob_r <= mem_oob;
          state_r  <= cont_r;
        end
        S_WR: begin
          widx_r <= widx_r + 2'd1;
          if (widx_r == wcnt_r) begin
            state_r <= cont_r;
          end
        end
        S_INIT_EXT: begin
          ext_incr_r <= AW'(INIT_EXT);
          state_r    <= S_EXT;
        end
        S_AL_START: begin
          if (size_r == '0) begin
            state_r <= S_DONE;
          end else begin
            asize_r   <= asize_calc;
            bp_r      <= rover_r;
            rd_addr_r <= rover_r - AW'(4);
            cont_r    <= S_FIT_CHK;
            state_r   <= S_RD;
          end
        end
        // next-fit walk, one header per read
        S_FIT_CHK: begin
          if (rd_size == '0 || bp_r > brk_r) begin
            ext_incr_r <= asize_r;
            state_r    <= S_EXT;
          end else if (!rd_used && asize_r <= rd_size) begin
            rover_r   <= bp_r;
            rd_addr_r <= bp_r - AW'(4);
            cont_r    <= S_PL_DEC;
            state_r   <= S_RD;
          end else begin
            bp_r      <= bp_r + rd_size;
            rd_addr_r <= bp_r + rd_size - AW'(4);
            cont_r    <= S_FIT_CHK;
            state_r   <= S_RD;
          end
        end
        // heap growth through the break
        S_EXT: begin
          if (ext_sum > (AW+1)'(HEAP_BYTES)) begin
            res_status_r <= 1'(STATUS_OOM);
            res_addr_r   <= '0;
            state_r      <= S_DONE;
          end else begin
            bp_r       <= brk_r;
            brk_r      <= ext_sum[AW-1:0];
            wa_r[0]    <= brk_r - AW'(4);              wv_r[0] <= 32'(ext_incr_r);
            wa_r[1]    <= ext_sum[AW-1:0] - AW'(8);    wv_r[1] <= 32'(ext_incr_r);
            wa_r[2]    <= ext_sum[AW-1:0] - AW'(4);    wv_r[2] <= 32'd1;
            wcnt_r     <= 2'd2;
            widx_r     <= 2'd0;
            ext_mode_r <= 1'b1;
            cont_r     <= S_M0;
            state_r    <= S_WR;
          end
        end
        // coalesce: gather previous and next tags
        S_M0: begin
          rd_addr_r <= bp_r - AW'(8);
          cont_r    <= S_M1;
          state_r   <= S_RD;
        end
        S_M1: begin
          prev_r    <= bp_r - rd_size;
          rd_addr_r <= bp_r - rd_size - AW'(4);
          cont_r    <= S_M2;
          state_r   <= S_RD;
        end
        S_M2: begin
          psz_r     <= rd_size;
          rd_addr_r <= prev_r + rd_size - AW'(8);
          cont_r    <= S_M3;
          state_r   <= S_RD;
        end
        S_M3: begin
          pa_r      <= rd_used;
          rd_addr_r <= bp_r - AW'(4);
          cont_r    <= S_M4;
          state_r   <= S_RD;
        end
        S_M4: begin
          sz_r      <= rd_size;
          nxt_r     <= bp_r + rd_size;
          rd_addr_r <= bp_r + rd_size - AW'(4);
          cont_r    <= S_M_DEC;
          state_r   <= S_RD;
        end
        S_M_DEC: begin
          widx_r <= 2'd0;
          wcnt_r <= 2'd1;
          cont_r <= S_M_END;
          if (pa_r && !rd_used) begin
            wa_r[0] <= bp_r - AW'(4);                   wv_r[0] <= 32'(sz_r + rd_size);
            wa_r[1] <= bp_r + sz_r + rd_size - AW'(8);  wv_r[1] <= 32'(sz_r + rd_size);
            state_r <= S_WR;
          end else if (!pa_r && rd_used) begin
            wa_r[0] <= bp_r + sz_r - AW'(8);  wv_r[0] <= 32'(sz_r + psz_r);
            wa_r[1] <= prev_r - AW'(4);       wv_r[1] <= 32'(sz_r + psz_r);
            bp_r    <= prev_r;
            state_r <= S_WR;
          end else if (!pa_r && !rd_used) begin
            nxt_r     <= nxt_r + rd_size - AW'(8);
            rd_addr_r <= nxt_r + rd_size - AW'(8);
            cont_r    <= S_M_NF;
            state_r   <= S_RD;
          end else begin
            state_r <= S_M_END;
          end
        end
        S_M_NF: begin
          wa_r[0] <= prev_r - AW'(4);  wv_r[0] <= 32'(sz_r + psz_r + rd_size);
          wa_r[1] <= nxt_r;            wv_r[1] <= 32'(sz_r + psz_r + rd_size);
          wcnt_r  <= 2'd1;
          widx_r  <= 2'd0;
          bp_r    <= prev_r;
          cont_r  <= S_M_END;
          state_r <= S_WR;
        end
        S_M_END: begin
          rover_r <= bp_r;
          if (ext_mode_r) begin
            ext_mode_r <= 1'b0;
            if (op_r == ACT_INIT) begin
              state_r <= S_DONE;
            end else begin
              rd_addr_r <= bp_r - AW'(4);
              cont_r    <= S_PL_DEC;
              state_r   <= S_RD;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        // place: split when the remainder is large enough
        S_PL_DEC: begin
          widx_r  <= 2'd0;
          cont_r  <= S_AL_OK;
          state_r <= S_WR;
          if (rd_size >= asize_r + AW'(SPLIT_MIN)) begin
            wa_r[0] <= bp_r - AW'(4);            wv_r[0] <= 32'(asize_r) | 32'd1;
            wa_r[1] <= bp_r + asize_r - AW'(8);  wv_r[1] <= 32'(asize_r) | 32'd1;
            wa_r[2] <= bp_r + asize_r - AW'(4);  wv_r[2] <= 32'(rd_size - asize_r);
            wa_r[3] <= bp_r + rd_size - AW'(8);  wv_r[3] <= 32'(rd_size - asize_r);
            wcnt_r  <= 2'd3;
            rover_r <= bp_r + asize_r;
          end else begin
            wa_r[0] <= bp_r - AW'(4);            wv_r[0] <= 32'(rd_size) | 32'd1;
            wa_r[1] <= bp_r + rd_size - AW'(8);  wv_r[1] <= 32'(rd_size) | 32'd1;
            wcnt_r  <= 2'd1;
            rover_r <= bp_r;
          end
        end
        S_AL_OK: begin
          res_addr_r <= bp_r;
          if (moving_r) begin
            res_copy_r <= copy_sat;
            state_r    <= S_REL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_REL: begin
          rd_addr_r <= p_r - AW'(4);
          cont_r    <= S_REL_W;
          state_r   <= S_RD;
        end
        S_REL_W: begin
          wa_r[0]    <= p_r - AW'(4);            wv_r[0] <= 32'(rd_size);
          wa_r[1]    <= p_r + rd_size - AW'(8);  wv_r[1] <= 32'(rd_size);
          wcnt_r     <= 2'd1;
          widx_r     <= 2'd0;
          bp_r       <= p_r;
          ext_mode_r <= 1'b0;
          cont_r     <= S_M0;
          state_r    <= S_WR;
        end
        // resize: try to absorb following free blocks
        S_RS_OLD: begin
          old_r  <= rd_size;
          need_r <= size_r + 17'd8;
          if (AW'(size_r) + AW'(8) <= rd_size) begin
            res_addr_r <= p_r;
            state_r    <= S_DONE;
          end else begin
            t_r       <= p_r;
            tot_r     <= rd_size;
            rd_addr_r <= p_r - AW'(4);
            cont_r    <= S_RS_T;
            state_r   <= S_RD;
          end
        end
        S_RS_T: begin
          if (rd_size == '0 || t_r + rd_size > brk_r) begin
            moving_r <= 1'b1;
            size_r   <= need_r;
            state_r  <= S_AL_START;
          end else begin
            nxt_r     <= t_r + rd_size;
            rd_addr_r <= t_r + rd_size - AW'(4);
            cont_r    <= S_RS_N;
            state_r   <= S_RD;
          end
        end
        S_RS_N: begin
          if (rd_used || rd_size == '0) begin
            moving_r <= 1'b1;
            size_r   <= need_r;
            state_r  <= S_AL_START;
          end else if (AW'(need_r) <= rs_tot) begin
            if (rover_r > p_r && rover_r < p_r + rs_tot) begin
              rover_r <= p_r;
            end
            wa_r[0]    <= p_r - AW'(4);           wv_r[0] <= 32'(rs_tot) | 32'd1;
            wa_r[1]    <= p_r + rs_tot - AW'(8);  wv_r[1] <= 32'(rs_tot) | 32'd1;
            wcnt_r     <= 2'd1;
            widx_r     <= 2'd0;
            res_addr_r <= p_r;
            cont_r     <= S_DONE;
            state_r    <= S_WR;
          end else begin
            tot_r     <= rs_tot;
            t_r       <= nxt_r;
            rd_addr_r <= nxt_r - AW'(4);
            cont_r    <= S_RS_T;
            state_r   <= S_RD;
          end
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r[15:0];
            out_copy_r   <= res_copy_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `NFBT_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `NFBT_ASSERT_IMP(a_brk_bound, 1'b1, brk_r <= AW'(HEAP_BYTES))
  `NFBT_ASSERT_IMP(a_fail_null, out_ch.valid && out_ch.status, out_ch.result_address == 16'd0 && out_ch.copy_bytes == 16'd0)

endmodule

FILE: src/nfbt_heap_mem.sv
// Single-port heap word memory with registered read data.
// No package dependencies.
module nfbt_heap_mem #(
  parameter int WORDS = 16384,
  parameter int IW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [WORDS];

  // one address per cycle: a write when enabled, and always a registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
